// ===== design/hpc_pkg.sv =====
// Shared constants, config register codes and types for the Bayer hot-pixel corrector.
// No dependencies; compiled first.
package hpc_pkg;

  localparam int MAX_WIDTH_DEF  = 8192;
  localparam int PIXEL_BITS     = 16;
  localparam int MAX_HEIGHT     = 8192;
  localparam int ROW_W          = $clog2(MAX_HEIGHT);
  localparam int HV_W           = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_SLOTS      = 5;
  localparam int SLOT_W         = 3;
  localparam int STR_W          = 10;
  localparam int MID_W          = PIXEL_BITS + STR_W;
  localparam int DIM_SHIFT      = 9;
  localparam int GEOM_W         = 14;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int OUT_FIFO_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_STRENGTH     = 3'd2,
    CFG_THRESHOLD    = 3'd3,
    CFG_PERMISSIVE   = 3'd4
  } cfg_idx_t;

  localparam logic [GEOM_W-1:0]     RST_FRAME_WIDTH  = GEOM_W'(8192);
  localparam logic [GEOM_W-1:0]     RST_FRAME_HEIGHT = GEOM_W'(8192);
  localparam logic [STR_W-1:0]      RST_STRENGTH     = STR_W'(64);
  localparam logic [PIXEL_BITS-1:0] RST_THRESHOLD    = PIXEL_BITS'(3277);

  typedef logic [ROW_SLOTS-1:0][PIXEL_BITS-1:0] hpc_lanes_t;

  typedef struct packed {
    logic [SLOT_W-1:0] ctr_slot;
    logic [SLOT_W-1:0] up_slot;
    logic [SLOT_W-1:0] dn_slot;
    logic              interior;
    logic              last;
  } hpc_tap_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  was_fixed;
    logic                  frame_last;
  } hpc_result_t;

endpackage

// ===== design/hpc_ifs.sv =====
// Valid/ready channel interfaces: pixel input, corrected output, config writes.
// Depends on hpc_pkg.
interface hpc_in_if;
  import hpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_in;
  logic                  flush;
  modport source (output valid, pixel_in, flush, input ready);
  modport sink   (input valid, pixel_in, flush, output ready);
endinterface

interface hpc_out_if;
  import hpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  was_fixed;
  logic                  frame_last;
  modport source (output valid, pixel_out, was_fixed, frame_last, input ready);
  modport sink   (input valid, pixel_out, was_fixed, frame_last, output ready);
endinterface

interface hpc_cfg_if;
  import hpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/bayer_hot_pixel_corrector.sv =====
// Top level of the Bayer hot-pixel corrector: config registers, credit flow control
// and the line store, position control, decision pipeline and result queue.
// Depends on hpc_pkg, hpc_ifs, hpc_line_mem, hpc_ctrl, hpc_judge, hpc_out_fifo.
//
// Usage:
//   in_chan   - one mosaic pixel per request in raster order; flush=1 marks a dummy
//               request that only drains pixels still held after the frame's last pixel.
//   out_chan  - one corrected pixel per request, with was_fixed and frame_last.
//   cfg_chan  - register writes (index, data); always ready. Write only while idle.
//               Writing frame_width or frame_height restarts the frame position.
// Each output pixel trails the input stream by 2*W+2 pixels so its neighbors two
// rows below are stored; after the last pixel of a frame each further request
// (flush or not) releases one held pixel. Its result passes the line store read
// registers and the decision registers into the result queue. Sustained rate is one
// pixel per cycle while out_chan keeps up: the line store is one dual-read memory
// touched once per request. in_chan.ready drops once the result queue and the two
// pipeline stages together hold four results, so a stalled receiver backs up the
// input after four results. Reset (synchronous, active low) restores register
// defaults and clears position and queue state; the line store needs no clearing.
module bayer_hot_pixel_corrector #(
  parameter int MAX_WIDTH = hpc_pkg::MAX_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hpc_in_if.sink    in_chan,
  hpc_out_if.source out_chan,
  hpc_cfg_if.sink   cfg_chan
);
  import hpc_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WV_W  = $clog2(MAX_WIDTH + 1);
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int OCC_W = CNT_W + 1;

  logic [GEOM_W-1:0]     frame_width_r, frame_height_r;
  logic [STR_W-1:0]      strength_r;
  logic [PIXEL_BITS-1:0] threshold_r;
  logic                  permissive_r;
  logic                  cfg_wr, restart, accept;
  logic [WV_W-1:0]       w_eff;
  logic [HV_W-1:0]       h_eff;
  logic [GEOM_W:0]       fw_x, fh_x;

  logic                  wr_en, rd_en, push;
  logic [COL_W-1:0]      wr_col, rd_col_a, rd_col_b;
  logic [SLOT_W-1:0]     wr_slot;
  logic [PIXEL_BITS-1:0] wr_data;
  hpc_tap_t              tap;
  hpc_lanes_t            rdata_a, rdata_b;
  hpc_result_t           result;
  logic [1:0]            inflight;
  logic [CNT_W-1:0]      fifo_cnt;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr         = cfg_chan.valid && cfg_chan.ready;
  assign restart        = cfg_wr && ((cfg_chan.index == CFG_FRAME_WIDTH) ||
                                     (cfg_chan.index == CFG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      strength_r     <= RST_STRENGTH;
      threshold_r    <= RST_THRESHOLD;
      permissive_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_chan.index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_chan.data[GEOM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_chan.data[GEOM_W-1:0];
        CFG_STRENGTH:     strength_r     <= cfg_chan.data[STR_W-1:0];
        CFG_THRESHOLD:    threshold_r    <= cfg_chan.data[PIXEL_BITS-1:0];
        CFG_PERMISSIVE:   permissive_r   <= cfg_chan.data[0];
        default: begin
        end
      endcase
    end
  end

  assign fw_x = (GEOM_W+1)'(frame_width_r);
  assign fh_x = (GEOM_W+1)'(frame_height_r);

  always_comb begin
    if (fw_x == '0) begin
      w_eff = WV_W'(1);
    end else if (fw_x > (GEOM_W+1)'(MAX_WIDTH)) begin
      w_eff = WV_W'(MAX_WIDTH);
    end else begin
      w_eff = WV_W'(fw_x);
    end
    if (fh_x == '0) begin
      h_eff = HV_W'(1);
    end else if (fh_x > (GEOM_W+1)'(MAX_HEIGHT)) begin
      h_eff = HV_W'(MAX_HEIGHT);
    end else begin
      h_eff = HV_W'(fh_x);
    end
  end

  assign in_chan.ready = (OCC_W'(fifo_cnt) + OCC_W'(inflight)) < OCC_W'(OUT_FIFO_DEPTH);
  assign accept        = in_chan.valid && in_chan.ready;

  hpc_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .accept   (accept),
    .flush    (in_chan.flush),
    .pixel    (in_chan.pixel_in),
    .wr_en    (wr_en),
    .wr_col   (wr_col),
    .wr_slot  (wr_slot),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_col_a (rd_col_a),
    .rd_col_b (rd_col_b),
    .tap      (tap)
  );

  hpc_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem (
    .clk     (clk),
    .we      (wr_en),
    .wcol    (wr_col),
    .wslot   (wr_slot),
    .wdata   (wr_data),
    .re      (rd_en),
    .rcol_a  (rd_col_a),
    .rcol_b  (rd_col_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  hpc_judge u_judge (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (rd_en),
    .tap_in     (tap),
    .rdata_a    (rdata_a),
    .rdata_b    (rdata_b),
    .strength   (strength_r),
    .threshold  (threshold_r),
    .permissive (permissive_r),
    .push       (push),
    .result     (result),
    .inflight   (inflight)
  );

  hpc_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .din      (result),
    .count    (fifo_cnt),
    .out_chan (out_chan)
  );

endmodule

// ===== design/hpc_line_mem.sv =====
// Five-row line store: one entry per column, one lane per row slot, lane write enable.
// Two registered read ports with write-first forwarding. Depends on hpc_pkg.
module hpc_line_mem #(
  parameter int MAX_WIDTH = hpc_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wcol,
  input  logic [hpc_pkg::SLOT_W-1:0]    wslot,
  input  logic [hpc_pkg::PIXEL_BITS-1:0] wdata,
  input  logic                          re,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rcol_a,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rcol_b,
  output hpc_pkg::hpc_lanes_t           rdata_a,
  output hpc_pkg::hpc_lanes_t           rdata_b
);
  import hpc_pkg::*;

  hpc_lanes_t            mem [MAX_WIDTH];
  hpc_lanes_t            q_a_r;
  hpc_lanes_t            q_b_r;
  logic                  hit_a_r;
  logic                  hit_b_r;
  logic [SLOT_W-1:0]     fwd_slot_r;
  logic [PIXEL_BITS-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wcol][wslot] <= wdata;
    end
    if (re) begin
      q_a_r      <= mem[rcol_a];
      q_b_r      <= mem[rcol_b];
      hit_a_r    <= we && (wcol == rcol_a);
      hit_b_r    <= we && (wcol == rcol_b);
      fwd_slot_r <= wslot;
      fwd_data_r <= wdata;
    end
  end

  always_comb begin
    rdata_a = q_a_r;
    rdata_b = q_b_r;
    if (hit_a_r) begin
      rdata_a[fwd_slot_r] = fwd_data_r;
    end
    if (hit_b_r) begin
      rdata_b[fwd_slot_r] = fwd_data_r;
    end
  end

endmodule

// ===== design/hpc_ctrl.sv =====
// Raster position tracking: write column/slot for input, read column/slots for output,
// input-to-output lag and frame completion. Depends on hpc_pkg.
module hpc_ctrl #(
  parameter int MAX_WIDTH = hpc_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  w_eff,
  input  logic [hpc_pkg::HV_W-1:0]        h_eff,
  input  logic                            accept,
  input  logic                            flush,
  input  logic [hpc_pkg::PIXEL_BITS-1:0]  pixel,
  output logic                            wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]    wr_col,
  output logic [hpc_pkg::SLOT_W-1:0]      wr_slot,
  output logic [hpc_pkg::PIXEL_BITS-1:0]  wr_data,
  output logic                            rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]    rd_col_a,
  output logic [$clog2(MAX_WIDTH)-1:0]    rd_col_b,
  output hpc_pkg::hpc_tap_t               tap
);
  import hpc_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WV_W  = $clog2(MAX_WIDTH + 1);
  localparam int CW2   = WV_W + 1;
  localparam int LAG_W = $clog2(2 * MAX_WIDTH + 4);
  localparam logic [SLOT_W:0] NSLOTS = (SLOT_W+1)'(ROW_SLOTS);

  logic [COL_W-1:0]  in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SLOT_W-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic              done_r, done_nxt;
  logic [LAG_W-1:0]  lag_r, lag_nxt, lag_inc, lag_lim;
  logic [WV_W-1:0]   w_last;
  logic [HV_W-1:0]   h_last;
  logic              wr, in_wrap, out_wrap, done_now, emit, last;
  logic              row_ok, col_ok;

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] k);
    logic [SLOT_W:0] sum;
    sum = {1'b0, s} + {1'b0, k};
    if (sum >= NSLOTS) begin
      sum = sum - NSLOTS;
    end
    return sum[SLOT_W-1:0];
  endfunction

  assign w_last   = w_eff - WV_W'(1);
  assign h_last   = h_eff - HV_W'(1);
  assign lag_lim  = LAG_W'({w_eff, 1'b0}) + LAG_W'(3);
  assign wr       = accept && !flush && !done_r;
  assign in_wrap  = (WV_W'(in_col_r) == w_last);
  assign out_wrap = (WV_W'(out_col_r) == w_last);
  assign done_now = done_r || (wr && in_wrap && (HV_W'(in_row_r) == h_last));
  assign lag_inc  = lag_r + LAG_W'(wr);
  assign emit     = accept && (done_now ? (lag_inc != '0) : (lag_inc >= lag_lim));
  assign last     = done_now && (lag_inc == LAG_W'(1));

  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    in_slot_nxt  = in_slot_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_slot_nxt = out_slot_r;
    done_nxt     = done_now;
    lag_nxt      = lag_inc - LAG_W'(emit);
    if (wr) begin
      if (in_wrap) begin
        in_col_nxt  = '0;
        in_row_nxt  = in_row_r + ROW_W'(1);
        in_slot_nxt = slot_add(in_slot_r, SLOT_W'(1));
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
    end
    if (emit) begin
      if (out_wrap) begin
        out_col_nxt  = '0;
        out_row_nxt  = out_row_r + ROW_W'(1);
        out_slot_nxt = slot_add(out_slot_r, SLOT_W'(1));
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
    end
    if (restart || (emit && last)) begin
      in_col_nxt   = '0;
      in_row_nxt   = '0;
      in_slot_nxt  = '0;
      out_col_nxt  = '0;
      out_row_nxt  = '0;
      out_slot_nxt = '0;
      done_nxt     = 1'b0;
      lag_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      done_r     <= 1'b0;
      lag_r      <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      in_slot_r  <= in_slot_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
      done_r     <= done_nxt;
      lag_r      <= lag_nxt;
    end
  end

  assign row_ok = (out_row_r >= ROW_W'(2)) && ((HV_W'(out_row_r) + HV_W'(2)) < h_eff);
  assign col_ok = (out_col_r >= COL_W'(2)) && ((CW2'(out_col_r) + CW2'(2)) < CW2'(w_eff));

  assign wr_en    = wr;
  assign wr_col   = in_col_r;
  assign wr_slot  = in_slot_r;
  assign wr_data  = pixel;
  assign rd_en    = emit;
  assign rd_col_a = out_col_r;
  assign rd_col_b = (row_ok && col_ok) ? (out_col_r + COL_W'(2)) : out_col_r;

  always_comb begin
    tap.ctr_slot = out_slot_r;
    tap.up_slot  = slot_add(out_slot_r, SLOT_W'(3));
    tap.dn_slot  = slot_add(out_slot_r, SLOT_W'(2));
    tap.interior = row_ok && col_ok;
    tap.last     = last;
  end

  a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !done_r |-> lag_r < lag_lim)
    else $error("output lag exceeds two rows plus three");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    emit && last |=> (lag_r == '0) && !done_r && (out_col_r == '0) && (in_col_r == '0))
    else $error("frame position not cleared after final pixel");

endmodule

// ===== design/hpc_judge.sv =====
// Hot-pixel decision pipeline: lane select and multiply, then neighbor compare,
// vote count and brightest-dimmer pick. Depends on hpc_pkg.
module hpc_judge (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  hpc_pkg::hpc_tap_t               tap_in,
  input  hpc_pkg::hpc_lanes_t             rdata_a,
  input  hpc_pkg::hpc_lanes_t             rdata_b,
  input  logic [hpc_pkg::STR_W-1:0]       strength,
  input  logic [hpc_pkg::PIXEL_BITS-1:0]  threshold,
  input  logic                            permissive,
  output logic                            push,
  output hpc_pkg::hpc_result_t            result,
  output logic [1:0]                      inflight
);
  import hpc_pkg::*;

  localparam logic [2:0] NEED_STRICT = 3'd4;
  localparam logic [2:0] NEED_LOOSE  = 3'd3;

  logic                       s1_v_r, s2_v_r;
  hpc_tap_t                   tap_r;
  logic [PIXEL_BITS-1:0]      ctr, up_px, dn_px, rt_px;
  logic [PIXEL_BITS-1:0]      left_d1_r, left_d2_r, ctr2_r;
  logic [3:0][PIXEL_BITS-1:0] nb_r;
  logic [MID_W-1:0]           mid_r;
  logic                       hot_r, last_r;
  logic [3:0]                 dim;
  logic [3:0][PIXEL_BITS-1:0] cand;
  logic [PIXEL_BITS-1:0]      m01, m23, best;
  logic [2:0]                 cnt;
  logic                       fix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= rd_en;
      s2_v_r <= s1_v_r;
    end
  end

  assign ctr   = rdata_a[tap_r.ctr_slot];
  assign up_px = rdata_a[tap_r.up_slot];
  assign dn_px = rdata_a[tap_r.dn_slot];
  assign rt_px = rdata_b[tap_r.ctr_slot];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      tap_r <= tap_in;
    end
    if (s1_v_r) begin
      left_d1_r <= ctr;
      left_d2_r <= left_d1_r;
      ctr2_r    <= ctr;
      nb_r      <= {dn_px, rt_px, up_px, left_d2_r};
      mid_r     <= MID_W'(ctr) * MID_W'(strength);
      hot_r     <= tap_r.interior && (ctr > threshold);
      last_r    <= tap_r.last;
    end
  end

  always_comb begin
    cnt = '0;
    for (int k = 0; k < 4; k++) begin
      dim[k]  = mid_r > MID_W'({nb_r[k], {DIM_SHIFT{1'b0}}});
      cand[k] = dim[k] ? nb_r[k] : '0;
      cnt     = cnt + 3'(dim[k]);
    end
    m01  = (cand[0] > cand[1]) ? cand[0] : cand[1];
    m23  = (cand[2] > cand[3]) ? cand[2] : cand[3];
    best = (m01 > m23) ? m01 : m23;
    fix  = hot_r && (cnt >= (permissive ? NEED_LOOSE : NEED_STRICT));
  end

  assign push              = s2_v_r;
  assign result.pixel      = fix ? best : ctr2_r;
  assign result.was_fixed  = fix;
  assign result.frame_last = last_r;
  assign inflight          = {1'b0, s1_v_r} + {1'b0, s2_v_r};

  a_fix_dimmer: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && fix |-> mid_r > MID_W'({best, {DIM_SHIFT{1'b0}}}))
    else $error("replacement is not a dimmer neighbor");

endmodule

// ===== design/hpc_out_fifo.sv =====
// Small result queue that decouples the decision pipeline from the output channel.
// Depends on hpc_pkg and hpc_ifs.
module hpc_out_fifo (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    push,
  input  hpc_pkg::hpc_result_t                    din,
  output logic [$clog2(hpc_pkg::OUT_FIFO_DEPTH+1)-1:0] count,
  hpc_out_if.source                               out_chan
);
  import hpc_pkg::*;

  localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

  hpc_result_t      entry_r [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;

  assign pop = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

  assign count               = cnt_r;
  assign out_chan.valid      = (cnt_r != '0);
  assign out_chan.pixel_out  = entry_r[rd_ptr_r].pixel;
  assign out_chan.was_fixed  = entry_r[rd_ptr_r].was_fixed;
  assign out_chan.frame_last = entry_r[rd_ptr_r].frame_last;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < CNT_W'(OUT_FIFO_DEPTH))
    else $error("result queue overflow");

endmodule

// ===== tb/sv/hpc_checker.sv =====
// Checker for the Bayer hot-pixel corrector: watches the pixel, result and register
// channels, predicts each corrected pixel and compares it field by field.
// Depends on hpc_pkg and hpc_ifs.
module hpc_checker (
  input  logic        clk,
  input  logic        rst_n,
  hpc_in_if           in_mon,
  hpc_out_if          out_mon,
  hpc_cfg_if          cfg_mon,
  output int unsigned err_count,
  output int unsigned pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import hpc_pkg::*;

  logic [GEOM_W-1:0]     width_reg;
  logic [GEOM_W-1:0]     height_reg;
  logic [STR_W-1:0]      strength_reg;
  logic [PIXEL_BITS-1:0] thresh_reg;
  logic                  permissive_reg;

  logic [PIXEL_BITS-1:0] mosaic_rows [ROW_SLOTS][MAX_WIDTH_DEF];
  int unsigned           col_pos;
  int unsigned           row_pos;
  int unsigned           emitted;
  hpc_result_t           pending_pixels [$];

  initial begin
    err_count     = 0;
    pending_count = 0;
  end

  function automatic int unsigned clamp_dim(input logic [GEOM_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] stored(input int unsigned r, input int unsigned c);
    return mosaic_rows[r % ROW_SLOTS][c];
  endfunction

  task automatic restart_frame();
    col_pos = 0;
    row_pos = 0;
    emitted = 0;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    err_count++;
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got_v, want_v);
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_FRAME_WIDTH: begin
        width_reg = val[GEOM_W-1:0];
        restart_frame();
      end
      CFG_FRAME_HEIGHT: begin
        height_reg = val[GEOM_W-1:0];
        restart_frame();
      end
      CFG_STRENGTH:   strength_reg = val[STR_W-1:0];
      CFG_THRESHOLD:  thresh_reg = val[PIXEL_BITS-1:0];
      CFG_PERMISSIVE: permissive_reg = val[0];
      default: ;
    endcase
  endtask

  // Store one request and, when a pixel leaves the delay line, predict its correction.
  task automatic absorb_pixel(input logic [PIXEL_BITS-1:0] pix, input logic fl);
    int unsigned           w, h, total, got, orow, ocol, hits, need;
    logic                  emit;
    logic [PIXEL_BITS-1:0] ctr, best;
    logic [PIXEL_BITS-1:0] nb [4];
    logic [MID_W-1:0]      mid;
    hpc_result_t           res;

    w     = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h     = clamp_dim(height_reg, MAX_HEIGHT);
    total = w * h;
    got   = row_pos * w + col_pos;
    if (got > total) got = total;

    if (!fl && got < total) begin
      mosaic_rows[row_pos % ROW_SLOTS][col_pos] = pix;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      got++;
    end

    emit = (got >= total) ? (emitted < got) : (got >= emitted + 2 * w + 3);
    if (!emit) return;

    orow           = emitted / w;
    ocol           = emitted % w;
    ctr            = stored(orow, ocol);
    res.pixel      = ctr;
    res.was_fixed  = 1'b0;

    if (orow >= 2 && orow + 2 < h && ocol >= 2 && ocol + 2 < w && ctr > thresh_reg) begin
      nb[0] = stored(orow, ocol - 2);
      nb[1] = stored(orow - 2, ocol);
      nb[2] = stored(orow, ocol + 2);
      nb[3] = stored(orow + 2, ocol);
      mid   = MID_W'(ctr) * MID_W'(strength_reg);
      need  = permissive_reg ? 3 : 4;
      hits  = 0;
      best  = '0;
      foreach (nb[k]) begin
        if (mid > MID_W'(nb[k]) * 512) begin
          hits++;
          if (nb[k] > best) best = nb[k];
        end
      end
      if (hits >= need) begin
        res.pixel     = best;
        res.was_fixed = 1'b1;
      end
    end

    emitted++;
    res.frame_last = (emitted >= total);
    if (res.frame_last) restart_frame();
    pending_pixels.push_back(res);
  endtask

  task automatic check_result();
    hpc_result_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch("result with no request pending", out_mon.pixel_out, 0);
      return;
    end
    want = pending_pixels.pop_front();
    if (out_mon.pixel_out !== want.pixel)
      report_mismatch("pixel_out", out_mon.pixel_out, want.pixel);
    if (out_mon.was_fixed !== want.was_fixed)
      report_mismatch("was_fixed", out_mon.was_fixed, want.was_fixed);
    if (out_mon.frame_last !== want.frame_last)
      report_mismatch("frame_last", out_mon.frame_last, want.frame_last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg      = RST_FRAME_WIDTH;
      height_reg     = RST_FRAME_HEIGHT;
      strength_reg   = RST_STRENGTH;
      thresh_reg     = RST_THRESHOLD;
      permissive_reg = 1'b0;
      restart_frame();
      pending_pixels.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) apply_write(cfg_mon.index, cfg_mon.data);
      if (in_mon.valid && in_mon.ready) absorb_pixel(in_mon.pixel_in, in_mon.flush);
      if (out_mon.valid && out_mon.ready) check_result();
    end
    pending_count = pending_pixels.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the hot-pixel corrector testbench: clock, reset, pixel and register stimulus,
// receiver stalls, watchdog and verdict.
// Depends on hpc_pkg, hpc_ifs, bayer_hot_pixel_corrector and hpc_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hpc_pkg::*;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 400;
  localparam int CFG_NUM_REGS  = 5;
  localparam int EDGE_PIXELS   = 24;

  typedef enum int {SCENE_NOISE, SCENE_DARK, SCENE_EXTREME} scene_t;
  typedef enum int {RX_OPEN, RX_BUSY, RX_SPARSE, RX_BLOCKED} rx_mode_t;

  logic        clk;
  logic        rst_n;
  int unsigned fails;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned frame_w = MAX_WIDTH_DEF;
  int unsigned frame_h = MAX_HEIGHT;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;

  hpc_in_if  in_chan ();
  hpc_out_if out_chan ();
  hpc_cfg_if cfg_chan ();

  bayer_hot_pixel_corrector dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  hpc_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_mon       (cfg_chan),
    .err_count     (fails),
    .pending_count (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 64);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:    out_chan.ready = 1'b1;
      RX_BUSY:    out_chan.ready = ($urandom_range(0, 3) != 0);
      RX_SPARSE:  out_chan.ready = ($urandom_range(0, 3) == 0);
      RX_BLOCKED: out_chan.ready = ((rx_left % 16) >= 12);
      default:    out_chan.ready = 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_req(input logic [PIXEL_BITS-1:0] pix, input logic fl);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_chan.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 20);
    end
    in_chan.valid    = 1'b1;
    in_chan.pixel_in = pix;
    in_chan.flush    = fl;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_chan.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_chan.valid = 1'b1;
    cfg_chan.index = idx;
    cfg_chan.data  = val;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  // Unused upper data bits get random junk half of the time.
  task automatic set_reg(input cfg_idx_t r, input int unsigned v);
    int unsigned           bits;
    logic [CFG_DATA_W-1:0] word;
    case (r)
      CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: bits = GEOM_W;
      CFG_STRENGTH:                      bits = STR_W;
      CFG_THRESHOLD:                     bits = PIXEL_BITS;
      default:                           bits = 1;
    endcase
    word = CFG_DATA_W'(v);
    if ($urandom_range(0, 1) == 1) word = word | (CFG_DATA_W'($urandom) << bits);
    cfg_write(r, word);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    set_reg(CFG_FRAME_WIDTH, w);
    set_reg(CFG_FRAME_HEIGHT, h);
    frame_w = (w == 0) ? 1 : (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
    frame_h = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endtask

  task automatic set_detection(input logic all);
    if (all || $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 4))
        0:       set_reg(CFG_STRENGTH, 0);
        1:       set_reg(CFG_STRENGTH, 1023);
        2:       set_reg(CFG_STRENGTH, RST_STRENGTH);
        default: set_reg(CFG_STRENGTH, $urandom_range(0, 1023));
      endcase
    end
    if (all || $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 4))
        0:       set_reg(CFG_THRESHOLD, 0);
        1:       set_reg(CFG_THRESHOLD, 65535);
        2:       set_reg(CFG_THRESHOLD, $urandom_range(0, 4095));
        default: set_reg(CFG_THRESHOLD, $urandom_range(0, 65535));
      endcase
    end
    if (all || $urandom_range(0, 1) == 1) set_reg(CFG_PERMISSIVE, $urandom_range(0, 1));
  endtask

  function automatic logic [PIXEL_BITS-1:0] gen_pixel(input scene_t scene,
                                                      input int unsigned bg_max);
    case (scene)
      SCENE_DARK:
        return ($urandom_range(0, 4) == 0) ? PIXEL_BITS'($urandom_range(1024, 65535))
                                           : PIXEL_BITS'($urandom_range(0, bg_max));
      SCENE_EXTREME: return ($urandom_range(0, 1) == 1) ? '1 : '0;
      default:       return PIXEL_BITS'($urandom);
    endcase
  endfunction

  // Sends npix pixels of a frame; a whole frame is followed by the drain requests.
  task automatic send_frame(input scene_t scene, input int unsigned npix);
    int unsigned bg_max, drains, total;
    total = frame_w * frame_h;
    case ($urandom_range(0, 3))
      0:       bg_max = 0;
      1:       bg_max = 15;
      2:       bg_max = 255;
      default: bg_max = 2047;
    endcase
    repeat (npix) begin
      if ($urandom_range(0, 15) == 0) send_req(PIXEL_BITS'($urandom), 1'b1);
      send_req(gen_pixel(scene, bg_max), 1'b0);
    end
    items_sent += npix;
    if (npix == total) begin
      drains = (total - 1 < 2 * frame_w + 2) ? total - 1 : 2 * frame_w + 2;
      repeat (drains) send_req(PIXEL_BITS'($urandom), $urandom_range(0, 3) != 0);
      items_sent += drains;
    end
  endtask

  initial begin
    int unsigned total, nframes;
    logic        first;

    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.pixel_in  = '0;
    in_chan.flush     = 1'b0;
    cfg_chan.valid    = 1'b0;
    cfg_chan.index    = '0;
    cfg_chan.data     = '0;
    out_chan.ready    = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: flushes before frame end, then a partial frame
    send_req(PIXEL_BITS'($urandom), 1'b1);
    send_req(PIXEL_BITS'($urandom), 1'b1);
    send_req('1, 1'b0);
    send_req('0, 1'b0);
    wait_drained();
    cfg_write(CFG_IDX_W'(CFG_NUM_REGS + $urandom_range(0, 2)), CFG_DATA_W'($urandom));
    // zero width saturates to one; tiny frame releases its pixels from the last one on
    set_geometry(0, 3);
    send_frame(SCENE_EXTREME, 3);
    send_req(PIXEL_BITS'($urandom), 1'b1);
    send_req(PIXEL_BITS'($urandom), 1'b1);
    wait_drained();

    // widest and tallest geometry, written past the top of the range; partial frames
    set_geometry(16383, 1);
    send_frame(SCENE_NOISE, EDGE_PIXELS);
    wait_drained();
    set_geometry(1, 16383);
    send_frame(SCENE_NOISE, EDGE_PIXELS);

    first      = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      wait_drained();
      if ($urandom_range(0, 3) == 0) set_geometry($urandom_range(0, 4), $urandom_range(0, 9));
      else set_geometry($urandom_range(5, 9), $urandom_range(5, 9));
      set_detection(first);
      first   = 1'b0;
      total   = frame_w * frame_h;
      nframes = $urandom_range(1, 2);
      for (int f = 0; f < nframes; f++) begin
        if (f > 0 && $urandom_range(0, 2) == 0) begin
          wait_drained();
          set_detection(1'b0);
        end
        send_frame(scene_t'($urandom_range(0, 2)), total);
      end
      if (total > 1 && $urandom_range(0, 5) == 0)
        send_frame(scene_t'($urandom_range(0, 2)), $urandom_range(1, total - 1));
    end

    wait_drained();
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
